// ===== rtl/core/planar_bitmap_pixel_access_top_macros.svh =====
// Assertion macros for the planar bitmap pixel access block.
`ifndef PLANAR_BITMAP_PIXEL_ACCESS_TOP_MACROS_SVH
`define PLANAR_BITMAP_PIXEL_ACCESS_TOP_MACROS_SVH

`ifndef SYNTH
// Property checked at every rising clock edge outside reset.
`define PBA_ASSERT(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// Condition in one cycle implies a consequence in the next.
`define PBA_ASSERT_NEXT(lbl, clk, rstn, cond, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (cond) |=> (cons)) else $error(msg);
`else
`define PBA_ASSERT(lbl, clk, rstn, prop, msg)
`define PBA_ASSERT_NEXT(lbl, clk, rstn, cond, cons, msg)
`endif

`endif

// ===== rtl/core/pba_pkg.sv =====
// Types and constants shared by the planar bitmap pixel access block.
`default_nettype none
package pba_pkg;

	// field widths
	localparam int X_W     = 13;
	localparam int Y_W     = 14;
	localparam int PIX_W   = 8;
	localparam int BPR_W   = 11;
	localparam int CNT_W   = 4;
	localparam int MODES_W = 16;
	localparam int CFG_W   = 16;
	localparam int CFG_IDX_W = 2;
	// widest byte offset: x/8 + y*bytes_per_row
	localparam int OFF_W   = 25;
	// plane slots carried in masks, one per bit of a colour index
	localparam int PLANE_SLOTS = 8;

	// queue between front and back
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = 2;
	localparam int QCNT_W      = 3;

	// request codes
	localparam logic REQ_READ  = 1'b0;
	localparam logic REQ_WRITE = 1'b1;

	// plane mode codes
	localparam logic [1:0] MODE_PRESENT = 2'd1;
	localparam logic [1:0] MODE_ONES    = 2'd2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_BYTES_PER_ROW = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PLANE_COUNT   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_PLANE_MODES   = 2'd2;

	// configuration reset values
	localparam logic [BPR_W-1:0]   BPR_RESET   = 11'd40;
	localparam logic [CNT_W-1:0]   COUNT_RESET = 4'd1;
	localparam logic [MODES_W-1:0] MODES_RESET = 16'h5555;

	// MSB-first pixel bit within a byte
	localparam logic [PIX_W-1:0] PIX_MSB = 8'h80;

	typedef struct packed {
		logic             req_type;
		logic [X_W-1:0]   pos_x;
		logic [Y_W-1:0]   pos_y;
		logic [PIX_W-1:0] write_value;
	} req_t;

	typedef struct packed {
		logic [PIX_W-1:0] read_value;
		logic             out_of_range;
	} rsp_t;

	// classified access handed from front to back
	typedef struct packed {
		logic                   is_write;
		logic                   oor;
		logic [OFF_W-1:0]       offset;
		logic [PIX_W-1:0]       bit_mask;
		logic [PIX_W-1:0]       write_value;
		logic [PLANE_SLOTS-1:0] present_mask;
		logic [PLANE_SLOTS-1:0] ones_mask;
	} job_t;

endpackage
`default_nettype wire

// ===== rtl/core/pba_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module pba_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/pba_front.sv =====
// Front end: config registers, request capture, offset and plane classification.
`default_nettype none
module pba_front #(
	parameter int PLANE_BYTES = 16384,
	parameter int MAX_PLANES  = 8
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           start,
	input  wire pba_pkg::req_t                  req,
	output logic                                busy,
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [pba_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [pba_pkg::CFG_W-1:0]      cfg_data,
	input  wire logic [pba_pkg::QCNT_W-1:0]     q_count,
	input  wire logic                           clearing,
	output logic                                push,
	output pba_pkg::job_t                       job
);

	logic [pba_pkg::BPR_W-1:0]   bpr_q;
	logic [pba_pkg::CNT_W-1:0]   count_q;
	logic [pba_pkg::MODES_W-1:0] modes_q;

	logic                        valid_s1;
	pba_pkg::req_t               req_s1;
	logic [pba_pkg::OFF_W-1:0]   prod_s1;

	logic                        accept;
	logic [pba_pkg::QCNT_W:0]    credit;
	logic [pba_pkg::CNT_W-1:0]   depth;
	logic [pba_pkg::OFF_W-1:0]   offset;

	assign cfg_ready = 1'b1;

	// items in flight toward the back; stall when the queue could overflow
	assign credit = {1'b0, q_count} + {{pba_pkg::QCNT_W{1'b0}}, valid_s1};
	assign busy   = clearing
		|| (credit >= (pba_pkg::QCNT_W + 1)'(pba_pkg::QUEUE_DEPTH));
	assign accept = start && !busy;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bpr_q   <= pba_pkg::BPR_RESET;
			count_q <= pba_pkg::COUNT_RESET;
			modes_q <= pba_pkg::MODES_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				pba_pkg::CFG_BYTES_PER_ROW: bpr_q   <= cfg_data[pba_pkg::BPR_W-1:0];
				pba_pkg::CFG_PLANE_COUNT:   count_q <= cfg_data[pba_pkg::CNT_W-1:0];
				pba_pkg::CFG_PLANE_MODES:   modes_q <= cfg_data[pba_pkg::MODES_W-1:0];
				default: ;
			endcase
		end
	end

	// stage 1 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	// stage 1 payload: request and row product
	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1  <= req;
			prod_s1 <= pba_pkg::OFF_W'(req.pos_y) * pba_pkg::OFF_W'(bpr_q);
		end
	end

	// byte offset, range check, and per-plane classification
	assign offset = pba_pkg::OFF_W'(req_s1.pos_x[pba_pkg::X_W-1:3]) + prod_s1;
	assign depth  = (count_q > pba_pkg::CNT_W'(MAX_PLANES))
		? pba_pkg::CNT_W'(MAX_PLANES) : count_q;

	always_comb begin
		logic in_use;
		job.is_write    = (req_s1.req_type == pba_pkg::REQ_WRITE);
		job.oor         = (offset >= pba_pkg::OFF_W'(PLANE_BYTES));
		job.offset      = offset;
		job.bit_mask    = pba_pkg::PIX_MSB >> req_s1.pos_x[2:0];
		job.write_value = req_s1.write_value;
		for (int i = 0; i < pba_pkg::PLANE_SLOTS; i++) begin
			in_use = (pba_pkg::CNT_W'(i) < depth);
			job.present_mask[i] = in_use && (modes_q[2*i +: 2] == pba_pkg::MODE_PRESENT);
			job.ones_mask[i]    = in_use && (modes_q[2*i +: 2] == pba_pkg::MODE_ONES);
		end
	end

	assign push = valid_s1;

endmodule
`default_nettype wire

// ===== rtl/core/pba_fifo.sv =====
// Short queue of classified accesses between front and back.
`default_nettype none
module pba_fifo (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        push,
	input  wire pba_pkg::job_t               push_job,
	input  wire logic                        pop,
	output pba_pkg::job_t                    head,
	output logic                             empty,
	output logic [pba_pkg::QCNT_W-1:0]       count
);

	pba_pkg::job_t                 slot_q [pba_pkg::QUEUE_DEPTH];
	logic [pba_pkg::QPTR_W-1:0]    wptr_q;
	logic [pba_pkg::QPTR_W-1:0]    rptr_q;
	logic [pba_pkg::QCNT_W-1:0]    count_q;

	assign head  = slot_q[rptr_q];
	assign empty = (count_q == '0);
	assign count = count_q;

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= rptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wptr_q] <= push_job;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/pba_back.sv =====
// Back end: clearing pass and read-modify-write over the plane memories.
`default_nettype none
module pba_back #(
	parameter int PLANE_BYTES = 16384,
	parameter int MAX_PLANES  = 8
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire pba_pkg::job_t   head,
	input  wire logic            empty,
	output logic                 pop,
	output logic                 clearing,
	output logic                 done,
	output pba_pkg::rsp_t        rsp
);

	localparam int ADDR_W = $clog2(PLANE_BYTES);

	typedef enum logic {
		ST_IDLE,
		ST_ACCESS
	} state_t;

	state_t                    state_q;
	pba_pkg::job_t             job_q;
	logic                      clr_active_q;
	logic [ADDR_W-1:0]         clr_addr_q;
	logic                      done_q;
	pba_pkg::rsp_t             rsp_q;

	logic [pba_pkg::PIX_W-1:0] rdata   [MAX_PLANES];
	logic [pba_pkg::PIX_W-1:0] wr_data [MAX_PLANES];
	logic [MAX_PLANES-1:0]     wr_en;
	logic [MAX_PLANES-1:0]     hit;
	logic [ADDR_W-1:0]         waddr;
	logic                      rd_en;

	assign clearing = clr_active_q;
	assign done     = done_q;
	assign rsp      = rsp_q;

	// take the next access only between items and after the clearing pass
	assign pop   = (state_q == ST_IDLE) && !empty && !clr_active_q;
	assign rd_en = pop && !head.oor;
	assign waddr = clr_active_q ? clr_addr_q : job_q.offset[ADDR_W-1:0];

	// per-plane write data and read gather
	always_comb begin
		for (int i = 0; i < MAX_PLANES; i++) begin
			if (clr_active_q) begin
				wr_en[i]   = 1'b1;
				wr_data[i] = '0;
			end else begin
				wr_en[i]   = (state_q == ST_ACCESS) && job_q.is_write && !job_q.oor
					&& job_q.present_mask[i];
				wr_data[i] = job_q.write_value[i] ? (rdata[i] | job_q.bit_mask)
					: (rdata[i] & ~job_q.bit_mask);
			end
			hit[i] = job_q.ones_mask[i]
				|| (job_q.present_mask[i] && ((rdata[i] & job_q.bit_mask) != '0));
		end
	end

	for (genvar g = 0; g < MAX_PLANES; g++) begin : g_plane
		pba_ram #(
			.WIDTH (pba_pkg::PIX_W),
			.DEPTH (PLANE_BYTES)
		) u_ram (
			.clk   (clk),
			.we    (wr_en[g]),
			.waddr (waddr),
			.wdata (wr_data[g]),
			.re    (rd_en),
			.raddr (head.offset[ADDR_W-1:0]),
			.rdata (rdata[g])
		);
	end

	// sequencer, clearing pass and registered result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			clr_active_q <= 1'b1;
			clr_addr_q   <= '0;
			done_q       <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (clr_active_q) begin
				if (clr_addr_q == ADDR_W'(PLANE_BYTES - 1)) begin
					clr_active_q <= 1'b0;
				end
				clr_addr_q <= clr_addr_q + 1'b1;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (pop) begin
						job_q   <= head;
						state_q <= ST_ACCESS;
					end
				end
				ST_ACCESS: begin
					done_q             <= 1'b1;
					rsp_q.out_of_range <= job_q.oor;
					rsp_q.read_value   <= (job_q.is_write || job_q.oor) ? '0
						: pba_pkg::PIX_W'(hit);
					state_q            <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/planar_bitmap_pixel_access_top.sv =====
// Top level of the planar bitmap pixel access block.
`default_nettype none
// Reads or writes one pixel of a planar bitmap per command. A command is taken
// when start is high and busy is low; its result shows on rsp for one cycle
// with done high, having passed the front stage register, the queue, the back
// end job register and the result register. The receiver cannot stall, so
// results are never held. The back end takes no new item before it is through
// with the last one: it reads the addressed byte in all plane memories as it
// pops the item, then does the masked write back or the gather of the read.
// A four-entry queue sits between the front end and the back end; busy rises
// when the queue and the front stage together hold four items. After reset
// busy stays high while all plane memories are cleared; configuration writes
// are taken at any time (cfg_ready is always high) but belong in idle periods.
`include "planar_bitmap_pixel_access_top_macros.svh"
module planar_bitmap_pixel_access_top #(
	parameter int PLANE_BYTES = 16384,
	parameter int MAX_PLANES  = 8
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           start,
	input  wire pba_pkg::req_t                  req,
	output logic                                busy,
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [pba_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [pba_pkg::CFG_W-1:0]      cfg_data,
	output logic                                done,
	output pba_pkg::rsp_t                       rsp
);

	logic                          push;
	pba_pkg::job_t                 push_job;
	pba_pkg::job_t                 head;
	logic                          empty;
	logic                          pop;
	logic [pba_pkg::QCNT_W-1:0]    q_count;
	logic                          clearing;

	pba_front #(
		.PLANE_BYTES (PLANE_BYTES),
		.MAX_PLANES  (MAX_PLANES)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.req       (req),
		.busy      (busy),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.q_count   (q_count),
		.clearing  (clearing),
		.push      (push),
		.job       (push_job)
	);

	pba_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.head     (head),
		.empty    (empty),
		.count    (q_count)
	);

	pba_back #(
		.PLANE_BYTES (PLANE_BYTES),
		.MAX_PLANES  (MAX_PLANES)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.empty    (empty),
		.pop      (pop),
		.clearing (clearing),
		.done     (done),
		.rsp      (rsp)
	);

	// an out-of-range beat never carries a colour
	`PBA_ASSERT(a_oor_zero, clk, arst_n,
		!(done && rsp.out_of_range) || (rsp.read_value == '0),
		"out-of-range result with nonzero value")
	// no result while the memories are being cleared
	`PBA_ASSERT(a_clear_quiet, clk, arst_n, !(clearing && done), "result during clearing pass")
	// the queue never takes an entry while full, unless one leaves in the same cycle
	`PBA_ASSERT(a_no_overflow, clk, arst_n,
		!(push && !pop && (q_count == pba_pkg::QCNT_W'(pba_pkg::QUEUE_DEPTH))),
		"queue overflow")
	// a pop opens an access in which the back end neither pops nor gives a result
	`PBA_ASSERT_NEXT(a_pop_result, clk, arst_n, pop, !pop && !done,
		"back end overlap after pop")

endmodule
`default_nettype wire

// ===== tb/sv/tb_planar_bitmap_pixel_access_top.sv =====
// Testbench for the planar bitmap pixel access block: directed table, then random phases.
`timescale 1ns / 100ps
module tb_planar_bitmap_pixel_access_top;
	import pba_pkg::*;

	localparam int PLANE_BYTES  = 16384;
	localparam int MAX_PLANES   = 8;
	localparam int N_PHASES     = 8;
	localparam int PHASE_ITEMS  = 110;
	localparam int DRAIN_LIMIT  = 1000;
	localparam int SETTLE_CYCLES = 8;
	localparam int N_DIRECTED   = 35;
	// index with no register behind it, writes are dropped
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

	typedef enum logic {ROW_CFG, ROW_PIX} row_kind_t;

	typedef struct packed {
		row_kind_t              kind;
		logic [CFG_IDX_W-1:0]   idx;
		logic [CFG_W-1:0]       data;
		req_t                   pix;
		logic                   has_exp;
		rsp_t                   exp_rsp;
	} step_row_t;

	typedef struct packed {
		req_t pix;
		rsp_t rsp;
	} pending_t;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 start     = 1'b0;
	req_t                 req       = '0;
	logic                 busy;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data  = '0;
	logic                 done;
	rsp_t                 rsp;

	// shadow copy of the block: registers and bitplanes
	logic [BPR_W-1:0]   row_bytes   = BPR_RESET;
	logic [CNT_W-1:0]   plane_depth = COUNT_RESET;
	logic [MODES_W-1:0] mode_word   = MODES_RESET;
	bit [PIX_W-1:0]     bitplane [MAX_PLANES][PLANE_BYTES];

	pending_t pixel_result_q [$];
	int       mismatch_cnt = 0;
	int       burst_left   = 0;

	// directed rows: extremes, plane modes, range edge, depth zero and saturated
	step_row_t directed_rows [N_DIRECTED] = '{
		'{ROW_PIX, CFG_SPARE, 16'h0, '{REQ_READ,  13'd0,    14'd0,     8'h00}, 1'b1, '{8'h00, 1'b0}},
		'{ROW_PIX, CFG_SPARE, 16'h0, '{REQ_READ,  13'd8191, 14'd16383, 8'h00}, 1'b1, '{8'h00, 1'b1}},
		'{ROW_PIX, CFG_SPARE, 16'h0, '{REQ_WRITE, 13'd8191, 14'd16383, 8'hFF}, 1'b1, '{8'h00, 1'b1}},
		'{ROW_CFG, CFG_PLANE_COUNT, 16'hFFF8, '0, 1'b0, '0},
		'{ROW_PIX, CFG_SPARE, 16'h0, '{REQ_WRITE, 13'd0,    14'd0,     8'hFF}, 1'b1, '{8'h00, 1'b0}},
		'{ROW_PIX, CFG_SPARE, 16'h0, '{REQ_READ,  13'd0,    14'd0,     8'h00}, 1'b0, '0},
		'{ROW_PIX, CFG_SPARE, 16'h0, '{REQ_WRITE, 13'd7,    14'd0,     8'hA5}, 1'b1, '{8'h00, 1'b0}},
		'{ROW_PIX, CFG_SPARE, 16'h0, '{REQ_READ,  13'd7,    14'd0,     8'h00}, 1'b0, '0},
		'{ROW_PIX, CFG_SPARE, 16'h0, '{REQ_READ,  13'd1,    14'd0,     8'h00}, 1'b0, '0},
		// last byte of a plane, then the first byte past it
		'{ROW_PIX, CFG_SPARE, 16'h0, '{REQ_WRITE, 13'd191,  14'd409,   8'h3C}, 1'b1, '{8'h00, 1'b0}},
		'{ROW_PIX, CFG_SPARE, 16'h0, '{REQ_READ,  13'd191,  14'd409,   8'h00}, 1'b0, '0},
		'{ROW_PIX, CFG_SPARE, 16'h0, '{REQ_WRITE, 13'd192,  14'd409,   8'hFF}, 1'b1, '{8'h00, 1'b1}},
		'{ROW_PIX, CFG_SPARE, 16'h0, '{REQ_READ,  13'd192,  14'd409,   8'h00}, 1'b1, '{8'h00, 1'b1}},
		// absent, present, all-ones and the second absent code mixed over the planes
		'{ROW_CFG, CFG_PLANE_MODES, 16'h49E4, '0, 1'b0, '0},
		'{ROW_PIX, CFG_SPARE, 16'h0, '{REQ_READ,  13'd0,    14'd0,     8'h00}, 1'b0, '0},
		'{ROW_PIX, CFG_SPARE, 16'h0, '{REQ_WRITE, 13'd0,    14'd0,     8'h00}, 1'b0, '0},
		'{ROW_PIX, CFG_SPARE, 16'h0, '{REQ_READ,  13'd0,    14'd0,     8'h00}, 1'b0, '0},
		'{ROW_PIX, CFG_SPARE, 16'h0, '{REQ_READ,  13'd7,    14'd0,     8'h00}, 1'b0, '0},
		// zero depth: reads give 0, range flag still reported
		'{ROW_CFG, CFG_PLANE_COUNT, 16'h0000, '0, 1'b0, '0},
		'{ROW_PIX, CFG_SPARE, 16'h0, '{REQ_READ,  13'd7,    14'd0,     8'h00}, 1'b1, '{8'h00, 1'b0}},
		'{ROW_PIX, CFG_SPARE, 16'h0, '{REQ_WRITE, 13'd0,    14'd0,     8'hFF}, 1'b1, '{8'h00, 1'b0}},
		'{ROW_PIX, CFG_SPARE, 16'h0, '{REQ_READ,  13'd0,    14'd16383, 8'h00}, 1'b1, '{8'h00, 1'b1}},
		// depth above the plane count saturates; zero row pitch via masked data
		'{ROW_CFG, CFG_PLANE_COUNT, 16'h000F, '0, 1'b0, '0},
		'{ROW_CFG, CFG_BYTES_PER_ROW, 16'hF800, '0, 1'b0, '0},
		'{ROW_PIX, CFG_SPARE, 16'h0, '{REQ_READ,  13'd8191, 14'd16383, 8'h00}, 1'b0, '0},
		'{ROW_PIX, CFG_SPARE, 16'h0, '{REQ_WRITE, 13'd8191, 14'd16383, 8'h5A}, 1'b0, '0},
		'{ROW_CFG, CFG_PLANE_MODES, 16'hFFFF, '0, 1'b0, '0},
		'{ROW_PIX, CFG_SPARE, 16'h0, '{REQ_READ,  13'd8191, 14'd0,     8'h00}, 1'b1, '{8'h00, 1'b0}},
		'{ROW_CFG, CFG_BYTES_PER_ROW, 16'h07FF, '0, 1'b0, '0},
		'{ROW_PIX, CFG_SPARE, 16'h0, '{REQ_READ,  13'd0,    14'd8,     8'h00}, 1'b0, '0},
		'{ROW_PIX, CFG_SPARE, 16'h0, '{REQ_READ,  13'd8191, 14'd8,     8'h00}, 1'b1, '{8'h00, 1'b1}},
		'{ROW_CFG, CFG_SPARE, 16'hFFFF, '0, 1'b0, '0},
		'{ROW_CFG, CFG_PLANE_MODES, 16'hAAAA, '0, 1'b0, '0},
		'{ROW_PIX, CFG_SPARE, 16'h0, '{REQ_READ,  13'd8,    14'd0,     8'h00}, 1'b1, '{8'hFF, 1'b0}},
		'{ROW_PIX, CFG_SPARE, 16'h0, '{REQ_WRITE, 13'd8,    14'd0,     8'h00}, 1'b1, '{8'h00, 1'b0}}
	};

	planar_bitmap_pixel_access_top #(
		.PLANE_BYTES(PLANE_BYTES),
		.MAX_PLANES (MAX_PLANES)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.req      (req),
		.busy     (busy),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.done     (done),
		.rsp      (rsp)
	);

	always #1 clk = ~clk;

	// run limit
	initial begin
		#1_000_000;
		$display("== FAIL ==");
		$finish;
	end

	task automatic flag_mismatch(input string msg);
		$display("%0t ns mismatch: %s", $time, msg);
		mismatch_cnt++;
	endtask

	// pixel access on the shadow planes; updates them on writes
	function automatic rsp_t pix_access(input req_t r);
		longint unsigned ofs;
		logic [PIX_W-1:0] bitm;
		logic [1:0]       md;
		int               depth;
		rsp_t             res;
		ofs   = longint'(r.pos_x >> 3) + longint'(r.pos_y) * longint'(row_bytes);
		bitm  = PIX_MSB >> r.pos_x[2:0];
		depth = (int'(plane_depth) > MAX_PLANES) ? MAX_PLANES : int'(plane_depth);
		res   = '0;
		if (ofs >= PLANE_BYTES) begin
			res.out_of_range = 1'b1;
			return res;
		end
		for (int p = 0; p < depth; p++) begin
			md = mode_word[2*p +: 2];
			if (r.req_type == REQ_WRITE) begin
				// only present planes take the bit
				if (md == MODE_PRESENT) begin
					if (r.write_value[p])
						bitplane[p][int'(ofs)] |= bitm;
					else
						bitplane[p][int'(ofs)] &= ~bitm;
				end
			end else if (md == MODE_ONES ||
					(md == MODE_PRESENT && (bitplane[p][int'(ofs)] & bitm) != '0)) begin
				res.read_value[p] = 1'b1;
			end
		end
		return res;
	endfunction

	// sender gap: drawn at random, with occasional back-to-back bursts
	function automatic int draw_gap();
		if (burst_left > 0) begin
			burst_left--;
			return 0;
		end
		if ($urandom_range(0, 7) == 0) begin
			burst_left = $urandom_range(10, 40);
			return 0;
		end
		return $urandom_range(0, 17);
	endfunction

	// one request beat; start stays high when the next beat follows at once
	task automatic send_pixel(input req_t r, input int gap, input logic use_row,
			input rsp_t row_rsp);
		pending_t ent;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		req   <= r;
		@(posedge clk);
		while (busy) @(posedge clk);
		ent.pix = r;
		ent.rsp = pix_access(r);
		if (use_row)
			ent.rsp = row_rsp;
		pixel_result_q.push_back(ent);
	endtask

	// stop sending and wait for every outstanding result
	task automatic drain_results();
		int waited;
		waited = 0;
		start <= 1'b0;
		while (pixel_result_q.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		if (pixel_result_q.size() != 0) begin
			flag_mismatch($sformatf("%0d results never arrived", pixel_result_q.size()));
			pixel_result_q.delete();
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// register write beat, shadow updated once accepted
	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		case (idx)
			CFG_BYTES_PER_ROW: row_bytes   = data[BPR_W-1:0];
			CFG_PLANE_COUNT:   plane_depth = data[CNT_W-1:0];
			CFG_PLANE_MODES:   mode_word   = data[MODES_W-1:0];
			default:           ;
		endcase
		@(posedge clk);
	endtask

	// result checker: one result per done pulse, in order
	always @(posedge clk) begin : result_check
		pending_t want;
		if (arst_n && done) begin
			if (pixel_result_q.size() == 0) begin
				flag_mismatch($sformatf("unexpected result value %02h range %0b",
					rsp.read_value, rsp.out_of_range));
			end else begin
				want = pixel_result_q.pop_front();
				if (rsp.read_value !== want.rsp.read_value)
					flag_mismatch($sformatf("op %0b x %0d y %0d: value %02h, want %02h",
						want.pix.req_type, want.pix.pos_x, want.pix.pos_y,
						rsp.read_value, want.rsp.read_value));
				if (rsp.out_of_range !== want.rsp.out_of_range)
					flag_mismatch($sformatf("op %0b x %0d y %0d: range %0b, want %0b",
						want.pix.req_type, want.pix.pos_x, want.pix.pos_y,
						rsp.out_of_range, want.rsp.out_of_range));
			end
		end
	end

	// main sequence
	initial begin
		req_t             r;
		logic [BPR_W-1:0] bpr_val;
		logic [CNT_W-1:0] cnt_val;
		logic [MODES_W-1:0] modes_val;
		int               sel;
		int               ymax;
		int               room;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		for (int n = 0; n < N_DIRECTED; n++) begin
			if (directed_rows[n].kind == ROW_CFG) begin
				drain_results();
				cfg_write(directed_rows[n].idx, directed_rows[n].data);
			end else begin
				send_pixel(directed_rows[n].pix, draw_gap(), directed_rows[n].has_exp,
					directed_rows[n].exp_rsp);
			end
		end

		// random phases, each under its own register setting
		for (int ph = 0; ph < N_PHASES; ph++) begin
			drain_results();
			case (ph)
				0: begin bpr_val = 11'd1;    cnt_val = 4'd8;  modes_val = 16'h5555; end
				1: begin bpr_val = 11'd2047; cnt_val = 4'd8;  modes_val = 16'h5555; end
				2: begin
					bpr_val   = 11'd40;
					cnt_val   = 4'd15;
					modes_val = MODES_W'($urandom_range(0, 65535));
				end
				3: begin bpr_val = 11'd0;    cnt_val = 4'd0;  modes_val = 16'h5555; end
				4: begin bpr_val = 11'd1024; cnt_val = 4'd8;  modes_val = 16'h0000; end
				default: begin
					bpr_val   = BPR_W'($urandom_range(0, 2047));
					cnt_val   = ($urandom_range(0, 3) == 0) ? CNT_W'($urandom_range(0, 15))
						: 4'd8;
					modes_val = $urandom_range(0, 1) ? MODES_W'($urandom_range(0, 65535))
						: 16'h5555;
				end
			endcase
			// junk in the unused upper data bits
			cfg_write(CFG_BYTES_PER_ROW,
				CFG_W'(($urandom_range(0, 65535) & 16'hF800) | bpr_val));
			cfg_write(CFG_PLANE_COUNT,
				CFG_W'(($urandom_range(0, 65535) & 16'hFFF0) | cnt_val));
			cfg_write(CFG_PLANE_MODES, modes_val);

			for (int k = 0; k < PHASE_ITEMS; k++) begin
				sel = $urandom_range(0, 99);
				r.req_type    = 1'($urandom_range(0, 1));
				r.write_value = PIX_W'($urandom_range(0, 255));
				if (sel < 15) begin
					// anywhere, often past the plane end
					r.pos_x = X_W'($urandom_range(0, 8191));
					r.pos_y = Y_W'($urandom_range(0, 16383));
				end else if (sel < 70) begin
					// small window so reads land on earlier writes
					r.pos_x = X_W'($urandom_range(0, 23));
					r.pos_y = Y_W'($urandom_range(0, 3));
				end else begin
					// anywhere inside the plane
					ymax = (row_bytes == '0) ? 16383 : (PLANE_BYTES - 1) / int'(row_bytes);
					if (ymax > 16383)
						ymax = 16383;
					r.pos_y = Y_W'($urandom_range(0, ymax));
					room = PLANE_BYTES - 1 - int'(r.pos_y) * int'(row_bytes);
					if (room > 1023)
						room = 1023;
					r.pos_x = X_W'($urandom_range(0, room * 8 + 7));
				end
				send_pixel(r, draw_gap(), 1'b0, '0);
			end
		end

		drain_results();
		if (mismatch_cnt == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
